[src/pcu_pkg.sv]
// shared types and constants for the pbwt column unpermute block
package pcu_pkg;

	localparam int MAX_SAMPLES = 4096;
	localparam int MAX_SYMBOLS = 16;
	localparam int ADDR_W      = $clog2(MAX_SAMPLES);
	localparam int CNT_W       = ADDR_W + 1;
	localparam int SYM_W       = 4;
	localparam int BKT_W       = $clog2(MAX_SYMBOLS);
	localparam int SCOUNT_W    = 13;
	localparam int YCOUNT_W    = 5;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'b1;

	localparam logic [SCOUNT_W-1:0] SAMPLE_COUNT_RST = SCOUNT_W'(4096);
	localparam logic [YCOUNT_W-1:0] SYMBOL_COUNT_RST = YCOUNT_W'(2);

	typedef enum logic [2:0] {
		BK_NONE = 3'd0,
		BK_INC  = 3'd1,
		BK_PFX  = 3'd2,
		BK_BUMP = 3'd3,
		BK_CLR  = 3'd4
	} bkt_op_t;

	typedef struct packed {
		bkt_op_t          op;
		logic [BKT_W-1:0] bkt;
	} bkt_ctl_t;

	typedef enum logic [5:0] {
		ST_INIT = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_OUT  = 6'b000100,
		ST_PFX  = 6'b001000,
		ST_SCAN = 6'b010000,
		ST_COPY = 6'b100000
	} state_t;

	// symbols without a bucket of their own go to the last bucket
	function automatic logic [BKT_W-1:0] bucket_of(input logic [SYM_W-1:0] sym);
		logic [BKT_W-1:0] k;
		if (32'(sym) >= MAX_SYMBOLS) begin
			k = BKT_W'(MAX_SYMBOLS - 1);
		end else begin
			k = BKT_W'(sym);
		end
		return k;
	endfunction

endpackage

[src/pbwt_column_unpermute_core.sv]
// top level of the pbwt column unpermute decoder
// Each symbol request first reads the permutation entry at the current
// position, then loads the output register once it is free. After the last
// position of a column (sample_count positions) the block rebuilds the
// permutation and takes no request meanwhile: bucket prefix sums over all 16
// buckets, a scan that scatters the entries into a scratch ram, and a copy
// back into the permutation ram. After reset a clearing pass over all 4096
// entries loads the identity permutation before the first request is taken;
// configuration writes are taken at any time.
module pbwt_column_unpermute_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata,  // symbol[3:0], zero pad
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [15:0]                       m_tdata,  // sample_index[11:0], sample_symbol[15:12]
	output logic                              m_tlast,  // column_end
	output logic                              m_tuser,  // symbol_error
	input  logic                              cfg_we,
	input  logic [pcu_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  logic [pcu_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int AW = pcu_pkg::ADDR_W;
	localparam int CW = pcu_pkg::CNT_W;
	localparam int SW = pcu_pkg::SYM_W;

	pcu_pkg::state_t state_q;

	logic [pcu_pkg::SCOUNT_W-1:0] sample_count_q;
	logic [pcu_pkg::YCOUNT_W-1:0] symbol_count_q;

	logic [AW-1:0] pos_q;
	logic [CW-1:0] len_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] init_q;
	logic [SW-1:0] sym_q;
	logic          last_q;
	logic          err_q;
	logic          v_s1;
	logic [AW-1:0] addr_s1;

	logic          m_tvalid_q;
	logic [AW-1:0] m_index_q;
	logic [SW-1:0] m_sym_q;
	logic          m_last_q;
	logic          m_err_q;

	logic [SW-1:0] sym_in;
	logic [CW-1:0] eff_n;
	logic [pcu_pkg::YCOUNT_W-1:0] eff_sym;
	logic [CW-1:0] pos_next;
	logic          take;
	logic          out_free;
	logic          pass_rd;
	logic          last_in;
	logic          err_in;

	logic          perm_we, perm_re;
	logic [AW-1:0] perm_waddr, perm_raddr, perm_wdata, perm_rdata;
	logic          sym_re;
	logic [SW-1:0] sym_rdata;
	logic          scr_we, scr_re;
	logic [AW-1:0] scr_rdata;

	pcu_pkg::bkt_ctl_t        bctl;
	logic [CW-1:0]            bstart;

	assign sym_in   = s_tdata[SW-1:0];
	assign s_tready = (state_q == pcu_pkg::ST_IDLE);
	assign take     = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign pos_next = {1'b0, pos_q} + 1'b1;
	assign pass_rd  = cnt_q < len_q;

	always_comb begin
		if (sample_count_q == '0) begin
			eff_n = CW'(1);
		end else if (32'(sample_count_q) > pcu_pkg::MAX_SAMPLES) begin
			eff_n = CW'(pcu_pkg::MAX_SAMPLES);
		end else begin
			eff_n = CW'(sample_count_q);
		end
		if (32'(symbol_count_q) > pcu_pkg::MAX_SYMBOLS) begin
			eff_sym = pcu_pkg::YCOUNT_W'(pcu_pkg::MAX_SYMBOLS);
		end else begin
			eff_sym = symbol_count_q;
		end
	end

	assign last_in = pos_next >= eff_n;
	assign err_in  = pcu_pkg::YCOUNT_W'(sym_in) >= eff_sym;

	// memory port and bucket control steering
	always_comb begin
		perm_we    = 1'b0;
		perm_waddr = addr_s1;
		perm_wdata = scr_rdata;
		perm_re    = 1'b0;
		perm_raddr = cnt_q[AW-1:0];
		sym_re     = 1'b0;
		scr_we     = 1'b0;
		scr_re     = 1'b0;
		bctl.op    = pcu_pkg::BK_NONE;
		bctl.bkt   = pcu_pkg::bucket_of(sym_in);
		case (state_q)
			pcu_pkg::ST_INIT: begin
				perm_we    = 1'b1;
				perm_waddr = init_q;
				perm_wdata = init_q;
			end
			pcu_pkg::ST_IDLE: begin
				perm_re    = take;
				perm_raddr = pos_q;
				if (take) begin
					bctl.op = pcu_pkg::BK_INC;
				end
			end
			pcu_pkg::ST_PFX: begin
				bctl.op  = pcu_pkg::BK_PFX;
				bctl.bkt = cnt_q[pcu_pkg::BKT_W-1:0];
			end
			pcu_pkg::ST_SCAN: begin
				perm_re  = pass_rd;
				sym_re   = pass_rd;
				bctl.bkt = pcu_pkg::bucket_of(sym_rdata);
				if (v_s1) begin
					bctl.op = pcu_pkg::BK_BUMP;
					scr_we  = 1'b1;
				end
			end
			pcu_pkg::ST_COPY: begin
				scr_re  = pass_rd;
				perm_we = v_s1;
				if (!pass_rd && !v_s1) begin
					bctl.op = pcu_pkg::BK_CLR;
				end
			end
			default: begin
			end
		endcase
	end

	pcu_ram #(.WIDTH(AW), .DEPTH(pcu_pkg::MAX_SAMPLES)) u_perm (
		.clk   (clk),
		.we    (perm_we),
		.waddr (perm_waddr),
		.wdata (perm_wdata),
		.re    (perm_re),
		.raddr (perm_raddr),
		.rdata (perm_rdata)
	);

	pcu_ram #(.WIDTH(SW), .DEPTH(pcu_pkg::MAX_SAMPLES)) u_sym (
		.clk   (clk),
		.we    (take),
		.waddr (pos_q),
		.wdata (sym_in),
		.re    (sym_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (sym_rdata)
	);

	pcu_ram #(.WIDTH(AW), .DEPTH(pcu_pkg::MAX_SAMPLES)) u_scratch (
		.clk   (clk),
		.we    (scr_we),
		.waddr (bstart[AW-1:0]),
		.wdata (perm_rdata),
		.re    (scr_re),
		.raddr (cnt_q[AW-1:0]),
		.rdata (scr_rdata)
	);

	pcu_buckets u_buckets (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (bctl),
		.start  (bstart)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= pcu_pkg::SAMPLE_COUNT_RST;
			symbol_count_q <= pcu_pkg::SYMBOL_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				pcu_pkg::CFG_SAMPLE_COUNT: sample_count_q <= cfg_data[pcu_pkg::SCOUNT_W-1:0];
				pcu_pkg::CFG_SYMBOL_COUNT: symbol_count_q <= cfg_data[pcu_pkg::YCOUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= pcu_pkg::ST_INIT;
			pos_q      <= '0;
			len_q      <= '0;
			cnt_q      <= '0;
			init_q     <= '0;
			last_q     <= 1'b0;
			v_s1       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if ((state_q == pcu_pkg::ST_OUT) && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				pcu_pkg::ST_INIT: begin
					init_q <= init_q + 1'b1;
					if (init_q == '1) begin
						state_q <= pcu_pkg::ST_IDLE;
					end
				end
				pcu_pkg::ST_IDLE: begin
					if (take) begin
						last_q  <= last_in;
						len_q   <= pos_next;
						pos_q   <= last_in ? '0 : pos_next[AW-1:0];
						state_q <= pcu_pkg::ST_OUT;
					end
				end
				pcu_pkg::ST_OUT: begin
					if (out_free) begin
						cnt_q      <= '0;
						state_q    <= last_q ? pcu_pkg::ST_PFX : pcu_pkg::ST_IDLE;
					end
				end
				pcu_pkg::ST_PFX: begin
					if (cnt_q == CW'(pcu_pkg::MAX_SYMBOLS - 1)) begin
						cnt_q   <= '0;
						state_q <= pcu_pkg::ST_SCAN;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				pcu_pkg::ST_SCAN, pcu_pkg::ST_COPY: begin
					v_s1 <= pass_rd;
					if (pass_rd) begin
						cnt_q <= cnt_q + 1'b1;
					end else if (!v_s1) begin
						cnt_q   <= '0;
						state_q <= (state_q == pcu_pkg::ST_SCAN) ? pcu_pkg::ST_COPY
						                                         : pcu_pkg::ST_IDLE;
					end
				end
				default: begin
					state_q <= pcu_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		addr_s1 <= cnt_q[AW-1:0];
		if (take) begin
			sym_q <= sym_in;
			err_q <= err_in;
		end
		if ((state_q == pcu_pkg::ST_OUT) && out_free) begin
			m_index_q <= perm_rdata;
			m_sym_q   <= sym_q;
			m_last_q  <= last_q;
			m_err_q   <= err_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {m_sym_q, m_index_q};
	assign m_tlast  = m_last_q;
	assign m_tuser  = m_err_q;

endmodule

[src/pcu_ram.sv]
// simple dual-port synchronous ram with registered read data
module pcu_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[src/pcu_buckets.sv]
// per-symbol bucket counters, turned into running start offsets for the rebuild
module pcu_buckets (
	input  logic                    clk,
	input  logic                    arst_n,
	input  pcu_pkg::bkt_ctl_t       ctl,
	output logic [pcu_pkg::CNT_W-1:0] start
);

	logic [pcu_pkg::CNT_W-1:0] cnt_q [pcu_pkg::MAX_SYMBOLS];
	logic [pcu_pkg::CNT_W-1:0] acc_q;

	assign start = cnt_q[ctl.bkt];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < pcu_pkg::MAX_SYMBOLS; i++) begin
				cnt_q[i] <= '0;
			end
			acc_q <= '0;
		end else begin
			case (ctl.op)
				pcu_pkg::BK_INC, pcu_pkg::BK_BUMP: begin
					cnt_q[ctl.bkt] <= cnt_q[ctl.bkt] + 1'b1;
				end
				pcu_pkg::BK_PFX: begin
					// count becomes the start offset of its bucket
					cnt_q[ctl.bkt] <= acc_q;
					acc_q          <= acc_q + cnt_q[ctl.bkt];
				end
				pcu_pkg::BK_CLR: begin
					for (int i = 0; i < pcu_pkg::MAX_SYMBOLS; i++) begin
						cnt_q[i] <= '0;
					end
					acc_q <= '0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule
